>>> hdl/h2r_pkg.sv
// Shared types, constants and helpers for the HSL to RGB converter.
package h2r_pkg;

    localparam int FRAC_BITS = 12;
    localparam int W         = FRAC_BITS + 1;           // fraction width incl. the 1.0 bit
    localparam int CH_W      = W + 1;                   // channel value before byte scaling
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int THIRD     = (333 * ONE + 500) / 1000;
    localparam int B1        = (167 * ONE + 500) / 1000;
    localparam int HALF      = ONE / 2;
    localparam int B2        = (667 * ONE + 500) / 1000;
    localparam int LATENCY   = 5;                       // request edge to result cycle

    typedef struct packed {
        logic [12:0] hue;
        logic [12:0] saturation;
        logic [12:0] lightness;
    } t_hsl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // per-pixel values shared by all three channel pipes
    typedef struct packed {
        logic         gray;
        logic [W-1:0] l;
        logic [W-1:0] p;
        logic [W-1:0] q;
        logic [W-1:0] d;
    } t_shade;

    typedef enum logic [1:0] {
        REG_RISE,
        REG_FLAT_Q,
        REG_FALL,
        REG_FLAT_P
    } t_region;

    // wrap a shifted hue back into 0..ONE
    function automatic logic [W-1:0] wrap_hue(input logic signed [W:0] t);
        logic signed [W:0] v;
        v = t;
        if (v < 0) begin
            v = v + $signed((W+1)'(ONE));
        end
        if (v > $signed((W+1)'(ONE))) begin
            v = v - $signed((W+1)'(ONE));
        end
        if (v < 0) begin
            v = '0;
        end
        return v[W-1:0];
    endfunction

endpackage

>>> hdl/h2r_channel.sv
// One color channel: hue region, ramp multiply, select, scale to a byte.
module h2r_channel (
    input  logic                   i_clk,
    input  h2r_pkg::t_shade        i_shade,
    input  logic [h2r_pkg::W-1:0]  i_t,
    output logic [7:0]             o_byte
);

    localparam int W    = h2r_pkg::W;
    localparam int CH_W = h2r_pkg::CH_W;
    localparam int FB   = h2r_pkg::FRAC_BITS;

    // stage 3: region and ramp product
    h2r_pkg::t_region  n_region, r_region;
    logic [W-1:0]      n_mul;
    logic [2*W-1:0]    w_prod;
    logic [W:0]        n_frac, r_frac;
    h2r_pkg::t_shade   r_shade;

    always_comb begin
        n_mul    = '0;
        n_region = h2r_pkg::REG_FLAT_P;
        if (i_t < W'(h2r_pkg::B1)) begin
            n_region = h2r_pkg::REG_RISE;
            n_mul    = W'(6 * {3'b0, i_t});
        end else if (i_t < W'(h2r_pkg::HALF)) begin
            n_region = h2r_pkg::REG_FLAT_Q;
        end else if (i_t < W'(h2r_pkg::B2)) begin
            n_region = h2r_pkg::REG_FALL;
            n_mul    = W'(6 * {3'b0, W'(h2r_pkg::B2) - i_t});
        end
        w_prod = i_shade.d * n_mul;
        n_frac = w_prod[2*W-1:FB];
    end

    always_ff @(posedge i_clk) begin
        r_region <= n_region;
        r_frac   <= n_frac;
        r_shade  <= i_shade;
    end

    // stage 4: channel fraction
    logic [CH_W-1:0] n_chan, r_chan;

    always_comb begin
        case (r_region)
            h2r_pkg::REG_RISE,
            h2r_pkg::REG_FALL:   n_chan = CH_W'({1'b0, r_shade.p}) + CH_W'(r_frac);
            h2r_pkg::REG_FLAT_Q: n_chan = CH_W'(r_shade.q);
            h2r_pkg::REG_FLAT_P: n_chan = CH_W'(r_shade.p);
            default:             n_chan = CH_W'(r_shade.p);
        endcase
        if (r_shade.gray) begin
            n_chan = CH_W'(r_shade.l);
        end
    end

    always_ff @(posedge i_clk) begin
        r_chan <= n_chan;
    end

    // stage 5: times 255, truncate, saturate
    logic [CH_W+7:0]    w_scaled;
    logic [CH_W+7-FB:0] w_byte_wide;
    logic [7:0]         n_byte, r_byte;

    always_comb begin
        w_scaled    = {r_chan, 8'b0} - (CH_W+8)'(r_chan);
        w_byte_wide = w_scaled[CH_W+7:FB];
        n_byte      = (w_byte_wide > (CH_W+8-FB)'(255)) ? 8'hFF : w_byte_wide[7:0];
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

>>> hdl/hsl_to_rgb_converter_core.sv
// HSL to RGB converter top level: input clamp, q/p and hue shifts, channel pipes.
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+------------------------------------
//  request   | start, busy, i_hsl         | taken at an edge with start & !busy
//  result    | o_strobe, o_result         | one cycle per result, no backpressure
//
// Five register stages: clamp + q multiply, q/p/hue wrap, ramp multiply,
// channel select, byte scale. A request's result is registered through all
// five and shows with o_strobe; one request per cycle is sustained while busy
// is low. busy is high only while reset is held; reset clears the valid chain.
module hsl_to_rgb_converter_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  h2r_pkg::t_hsl   i_hsl,
    output logic            o_strobe,
    output h2r_pkg::t_rgb   o_result
);

    localparam int W   = h2r_pkg::W;
    localparam int FB  = h2r_pkg::FRAC_BITS;
    localparam int LAT = h2r_pkg::LATENCY;

    logic w_accept;
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // valid chain
    logic [LAT-1:0] n_vld, r_vld;
    assign n_vld = {r_vld[LAT-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: clamp to 1.0, one multiply toward q
    logic [W-1:0]    n_h, n_s, n_l, r_h, r_s, r_l;
    logic            n_lo, r_lo;
    logic [W:0]      n_fac;
    logic [2*W:0]    n_prod, r_prod;

    always_comb begin
        n_h    = (i_hsl.hue > 13'(h2r_pkg::ONE)) ? W'(h2r_pkg::ONE) : W'(i_hsl.hue);
        n_s    = (i_hsl.saturation > 13'(h2r_pkg::ONE)) ? W'(h2r_pkg::ONE)
                                                        : W'(i_hsl.saturation);
        n_l    = (i_hsl.lightness > 13'(h2r_pkg::ONE)) ? W'(h2r_pkg::ONE)
                                                       : W'(i_hsl.lightness);
        n_lo   = n_l < W'(h2r_pkg::HALF);
        // below half: l*(1+s); otherwise l*s, subtracted next stage
        n_fac  = n_lo ? ((W+1)'(h2r_pkg::ONE) + (W+1)'(n_s)) : (W+1)'(n_s);
        n_prod = n_l * n_fac;
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_s    <= n_s;
        r_l    <= n_l;
        r_lo   <= n_lo;
        r_prod <= n_prod;
    end

    // stage 2: q, p, spread, shifted hues
    logic [W+1:0]        w_fm, w_qsum, w_pdiff;
    logic [W-1:0]        w_q, w_p;
    logic signed [W:0]   w_tr, w_tb;
    h2r_pkg::t_shade     n_shade, r_shade;
    logic [W-1:0]        n_t [3];
    logic [W-1:0]        r_t [3];

    always_comb begin
        w_fm    = r_prod[2*W:FB];
        w_qsum  = (W+2)'(r_l) + (W+2)'(r_s) - w_fm;
        w_q     = r_lo ? w_fm[W-1:0] : w_qsum[W-1:0];
        w_pdiff = {1'b0, r_l, 1'b0} - (W+2)'(w_q);
        w_p     = w_pdiff[W+1] ? '0 : w_pdiff[W-1:0];

        n_shade.gray = (r_s == '0);
        n_shade.l    = r_l;
        n_shade.q    = w_q;
        n_shade.p    = w_p;
        n_shade.d    = (w_q > w_p) ? (w_q - w_p) : '0;

        w_tr   = $signed({1'b0, r_h}) + $signed((W+1)'(h2r_pkg::THIRD));
        w_tb   = $signed({1'b0, r_h}) - $signed((W+1)'(h2r_pkg::THIRD));
        n_t[0] = h2r_pkg::wrap_hue(w_tr);
        n_t[1] = r_h;
        n_t[2] = h2r_pkg::wrap_hue(w_tb);
    end

    always_ff @(posedge i_clk) begin
        r_shade <= n_shade;
        r_t     <= n_t;
    end

    // stages 3..5
    logic [7:0] w_byte [3];

    for (genvar gi = 0; gi < 3; gi++) begin : g_chan
        h2r_channel u_chan (
            .i_clk   (i_clk),
            .i_shade (r_shade),
            .i_t     (r_t[gi]),
            .o_byte  (w_byte[gi])
        );
    end

    assign o_strobe       = r_vld[LAT-1];
    assign o_result.red   = w_byte[0];
    assign o_result.green = w_byte[1];
    assign o_result.blue  = w_byte[2];

endmodule

>>> hdl/h2r_checker.sv
// Port-level checks for the HSL to RGB converter, bound to the top level.
module h2r_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input h2r_pkg::t_hsl i_hsl,
    input logic          o_strobe,
    input h2r_pkg::t_rgb o_result
);

    localparam int LAT = h2r_pkg::LATENCY;

    a_ready_out_of_reset: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy high outside reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("request produced no result");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without request");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_hsl.saturation == 13'd0) |->
            ##LAT (o_result.red == o_result.green && o_result.green == o_result.blue))
        else $error("zero saturation not gray");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_hsl.lightness == 13'd0) |->
            ##LAT (o_result.red == 8'd0 && o_result.green == 8'd0 && o_result.blue == 8'd0))
        else $error("zero lightness not black");

endmodule

bind hsl_to_rgb_converter_core h2r_checker u_h2r_checker (.*);

>>> tb/tb_hsl_to_rgb_converter_core.sv
// Self-checking testbench for the HSL to RGB converter core.
module tb_hsl_to_rgb_converter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB         = 12;
    localparam int UNIT       = 1 << FB;
    localparam int HUE_THIRD  = (333 * UNIT + 500) / 1000;
    localparam int RISE_END   = (167 * UNIT + 500) / 1000;
    localparam int MID        = UNIT / 2;
    localparam int FALL_END   = (667 * UNIT + 500) / 1000;
    localparam int N_RANDOM   = 1530;
    localparam int CYCLE_CAP  = 300000;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    h2r_pkg::t_hsl i_hsl = '0;
    logic o_strobe;
    h2r_pkg::t_rgb o_result;

    hsl_to_rgb_converter_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_hsl    (i_hsl),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    h2r_pkg::t_hsl pending_pixels[$];
    h2r_pkg::t_rgb expected_colors[$];

    int  n_sent      = 0;
    int  n_checked   = 0;
    int  n_gray      = 0;
    int  n_clamped   = 0;
    int  n_errors    = 0;
    int  gap_left    = 0;
    bit  burst_mode  = 1'b0;
    int  cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic longint clamp_unit(logic [12:0] v);
        return (v > UNIT) ? UNIT : longint'(v);
    endfunction

    function automatic longint ramp_channel(longint p, longint q, longint t);
        longint d;
        d = q - p;
        if (d < 0) d = 0;
        if (t < 0) t += UNIT;
        if (t > UNIT) t -= UNIT;
        if (t < 0) t = 0;
        if (t < RISE_END) return p + ((d * 6 * t) >> FB);
        if (t < MID) return q;
        if (t < FALL_END) return p + ((d * 6 * (FALL_END - t)) >> FB);
        return p;
    endfunction

    function automatic logic [7:0] scale_to_byte(longint c);
        longint v;
        if (c < 0) c = 0;
        v = (c * 255) >> FB;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    function automatic h2r_pkg::t_rgb hsl_to_rgb_pixel(h2r_pkg::t_hsl px);
        longint h, s, l, q, p;
        h2r_pkg::t_rgb c;
        h = clamp_unit(px.hue);
        s = clamp_unit(px.saturation);
        l = clamp_unit(px.lightness);
        if (s == 0) begin
            c.red   = scale_to_byte(l);
            c.green = c.red;
            c.blue  = c.red;
        end else begin
            if (l < MID)
                q = (l * (UNIT + s)) >> FB;
            else
                q = l + s - ((l * s) >> FB);
            p = 2 * l - q;
            if (p < 0) p = 0;
            c.red   = scale_to_byte(ramp_channel(p, q, h + HUE_THIRD));
            c.green = scale_to_byte(ramp_channel(p, q, h));
            c.blue  = scale_to_byte(ramp_channel(p, q, h - HUE_THIRD));
        end
        return c;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic void add_pixel(int h, int s, int l);
        h2r_pkg::t_hsl px;
        px.hue        = 13'(h);
        px.saturation = 13'(s);
        px.lightness  = 13'(l);
        pending_pixels.push_back(px);
    endfunction

    // hue values: a quarter near the channel breakpoints, plus or minus one; the rest random, some above one
    function automatic int pick_hue();
        int marks[10] = '{0, 684, 2048, 2732, 3416, 1368, 3412, 4096, 1364, 2728};
        int r, v;
        r = $urandom_range(99);
        if (r < 25) begin
            v = marks[$urandom_range(9)] + $urandom_range(2) - 1;
            return (v < 0) ? 0 : v;
        end
        if (r < 33) return $urandom_range(8191);
        return $urandom_range(UNIT);
    endfunction

    function automatic int pick_fraction(bit allow_zero);
        int r;
        r = $urandom_range(99);
        if (r < 8) return allow_zero ? 0 : 1;
        if (r < 12) return 1;
        if (r < 20) return UNIT;
        if (r < 26) return $urandom_range(8191);
        if (r < 32) return MID + $urandom_range(2) - 1;
        if (r < 36) return UNIT - 1;
        return $urandom_range(UNIT);
    endfunction

    function automatic int draw_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_hsl <= '0;
        end else if (!(start && busy)) begin
            if (start) begin
                expected_colors.push_back(hsl_to_rgb_pixel(i_hsl));
                n_sent++;
                if (i_hsl.saturation == 0) n_gray++;
                if (i_hsl.hue > UNIT || i_hsl.saturation > UNIT || i_hsl.lightness > UNIT)
                    n_clamped++;
            end
            if ($urandom_range(99) == 0) burst_mode = ~burst_mode;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                i_hsl    <= pending_pixels.pop_front();
                start    <= 1'b1;
                gap_left <= draw_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        h2r_pkg::t_rgb want;
        if (i_rst_n && o_strobe) begin
            if (expected_colors.size() == 0) begin
                $error("result with no request outstanding: %h", o_result);
                n_errors++;
            end else begin
                want = expected_colors.pop_front();
                n_checked++;
                if (o_result.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, o_result.red);
                    n_errors++;
                end
                if (o_result.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, o_result.green);
                    n_errors++;
                end
                if (o_result.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, o_result.blue);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_colors.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        // gray, extremes and inputs above one
        add_pixel(0, 0, 0);
        add_pixel(0, 0, UNIT);
        add_pixel(1234, 0, 8191);
        add_pixel(8191, 8191, 8191);
        add_pixel(0, UNIT, 0);
        // primaries and hue of exactly one turn
        add_pixel(0, UNIT, MID);
        add_pixel(1365, UNIT, MID);
        add_pixel(2731, UNIT, MID);
        add_pixel(UNIT, UNIT, MID);
        // hue on each side of the ramp breakpoints
        add_pixel(683, UNIT, MID);
        add_pixel(684, UNIT, MID);
        add_pixel(2047, UNIT, MID);
        add_pixel(2048, UNIT, MID);
        add_pixel(2732, UNIT, MID);
        add_pixel(3416, UNIT, MID);
        // dark and light branch of q, overshoot near full saturation
        add_pixel(1364, UNIT, 1024);
        add_pixel(3000, 2000, 3000);
        add_pixel(100, 1, UNIT - 1);
        add_pixel(UNIT - 1, UNIT, UNIT);
        add_pixel(700, 5000, MID - 1);
        add_pixel(1363, 3000, MID + 1);
        add_pixel(0, UNIT, UNIT - 1);
        add_pixel(4000, 6000, 100);

        for (int k = 0; k < N_RANDOM; k++)
            add_pixel(pick_hue(), pick_fraction(1'b1), pick_fraction(1'b1));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || start) @(posedge i_clk);
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (h2r_pkg::LATENCY + 4) @(posedge i_clk);

        $display("sent %0d pixels, checked %0d colors in %0d cycles",
                 n_sent, n_checked, cycle_count);
        $display("%0d gray pixels, %0d with a field above one", n_gray, n_clamped);
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
